// ----- rtl/core/tile_edge_cleaner_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tile edge cleaner
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TILE_EDGE_CLEANER_ASSERT_SVH
`define TILE_EDGE_CLEANER_ASSERT_SVH

`ifndef SYNTH
// check under reset gating
`define TEC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also holds during reset
`define TEC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TEC_ASSERT(lbl, prop, msg)
`define TEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/tec_pkg.sv -----
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types and constants of the tile edge cleaner.
// ----------------------------------------------------------------------------
`default_nettype none

package tec_pkg;

   localparam int PIX_W   = 8;
   localparam int CNT_W   = 7;
   localparam int OUT_W   = 11;
   localparam int CSR_A_W = 3;
   localparam int DIM_W   = 12;
   localparam int WIN_W   = 4;
   localparam int THR_W   = 7;

   localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
   localparam logic [PIX_W-1:0] PIX_EDGE  = 8'd0;

   typedef enum logic [CSR_A_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_WIN_WIDTH    = 3'd2,
      REG_WIN_HEIGHT   = 3'd3,
      REG_THRESHOLD    = 3'd4
   } csr_index_type;

   // position status of the next pixel
   typedef struct packed {
      logic in_tile;
      logic first;
      logic done;
   } tile_flags_type;

endpackage

`default_nettype wire

// ----- rtl/core/tile_edge_cleaner.sv -----
// ----------------------------------------------------------------------------
// tile_edge_cleaner: clears sparse edge tiles in an 8-bit edge map
// Flow: an accepted pixel is registered, then a pass-through pixel goes to the output
// register once the slot frees; the last pixel of a full tile starts the tile's emit,
// one S_EMIT, S_LOAD pair per output pixel. New input is stalled outside S_IDLE.
// Reset: synchronous; config registers return to defaults, position to frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_edge_cleaner #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int MAX_WIN    = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tec_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tec_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic      [tec_pkg::OUT_W-1:0]     rsp_out_row,
   output logic      [tec_pkg::OUT_W-1:0]     rsp_out_col,
   output logic                               rsp_last_of_run,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tec_pkg::CSR_A_W-1:0]   csr_index,
   input  wire logic [tec_pkg::DIM_W-1:0]     csr_data
);

   localparam int PW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 1);
   localparam int KW  = $clog2(MAX_WIN + 1);
   localparam int IW  = $clog2(MAX_WIN);
   localparam int BAW = $clog2(MAX_WIN * MAX_WIDTH);
   localparam int CAW = $clog2(MAX_WIDTH);

   typedef enum logic [1:0] {S_IDLE, S_UPD, S_EMIT, S_LOAD} state_type;

   state_type state_ff, state_in;

   logic [tec_pkg::DIM_W-1:0] img_w_ff, img_h_ff;
   logic [tec_pkg::WIN_W-1:0] win_w_ff, win_h_ff;
   logic [tec_pkg::THR_W-1:0] thr_ff;

   logic [PW-1:0] w_c;
   logic [RW-1:0] h_c;
   logic [KW-1:0] ww_c, wh_c;

   logic                       csr_wr;
   logic                       csr_restart;
   logic                       req_acc;
   logic                       out_free;
   logic                       advance;

   logic [PW-1:0]              col;
   logic [RW-1:0]              row;
   logic [IW-1:0]              cit, rib;
   tec_pkg::tile_flags_type    flags;
   logic [PW-1:0]              start;

   logic [tec_pkg::PIX_W-1:0]  pix_ff, pix_in;
   logic [PW-1:0]              start_ff, start_in;
   logic [RW-1:0]              top_ff, top_in;
   logic                       clear_ff, clear_in;
   logic [IW-1:0]              er_ff, er_in, ec_ff, ec_in;
   logic                       emit_last;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tec_pkg::PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic [tec_pkg::OUT_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [tec_pkg::OUT_W-1:0]  rsp_col_ff, rsp_col_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       cnt_we;
   logic [tec_pkg::CNT_W-1:0]  cnt_rd, cnt_new;
   logic                       band_we;
   logic [BAW-1:0]             band_waddr, band_raddr;
   logic [tec_pkg::PIX_W-1:0]  band_rd;

   // ---------------- configuration ----------------
   assign csr_ready = (state_ff == S_IDLE);
   assign csr_wr    = csr_valid && csr_ready;
   // only a write to an existing register restarts the frame
   assign csr_restart = csr_wr && (csr_index <= tec_pkg::REG_THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 12'd640;
         img_h_ff <= 12'd480;
         win_w_ff <= 4'd4;
         win_h_ff <= 4'd4;
         thr_ff   <= 7'd1;
      end else if (csr_wr) begin
         unique case (csr_index)
            tec_pkg::REG_IMAGE_WIDTH:  img_w_ff <= csr_data;
            tec_pkg::REG_IMAGE_HEIGHT: img_h_ff <= csr_data;
            tec_pkg::REG_WIN_WIDTH:    win_w_ff <= csr_data[tec_pkg::WIN_W-1:0];
            tec_pkg::REG_WIN_HEIGHT:   win_h_ff <= csr_data[tec_pkg::WIN_W-1:0];
            tec_pkg::REG_THRESHOLD:    thr_ff   <= csr_data[tec_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes: zero acts as one, large values saturate
   always_comb begin
      if (img_w_ff == '0)                      w_c = PW'(1);
      else if (32'(img_w_ff) > MAX_WIDTH)      w_c = PW'(MAX_WIDTH);
      else                                     w_c = PW'(img_w_ff);
      if (img_h_ff == '0)                      h_c = RW'(1);
      else if (32'(img_h_ff) > MAX_HEIGHT)     h_c = RW'(MAX_HEIGHT);
      else                                     h_c = RW'(img_h_ff);
      if (win_w_ff == '0)                      ww_c = KW'(1);
      else if (32'(win_w_ff) > MAX_WIN)        ww_c = KW'(MAX_WIN);
      else                                     ww_c = KW'(win_w_ff);
      if (win_h_ff == '0)                      wh_c = KW'(1);
      else if (32'(win_h_ff) > MAX_WIN)        wh_c = KW'(MAX_WIN);
      else                                     wh_c = KW'(win_h_ff);
   end

   // ---------------- position ----------------
   tec_tracker #(.PW(PW), .RW(RW), .KW(KW), .IW(IW)) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_restart),
      .advance (advance),
      .w       (w_c),
      .h       (h_c),
      .ww      (ww_c),
      .wh      (wh_c),
      .col     (col),
      .row     (row),
      .cit     (cit),
      .rib     (rib),
      .flags   (flags)
   );

   assign start = col - PW'(cit);

   // ---------------- memories ----------------
   tec_ram #(.WIDTH(tec_pkg::CNT_W), .DEPTH(MAX_WIDTH)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (start[CAW-1:0]),
      .wr_data (cnt_new),
      .rd_addr (start[CAW-1:0]),
      .rd_data (cnt_rd)
   );

   assign band_waddr = BAW'(32'(rib) * MAX_WIDTH) + BAW'(col);
   assign band_raddr = BAW'(32'(er_ff) * MAX_WIDTH) + BAW'(start_ff + PW'(ec_ff));

   tec_ram #(.WIDTH(tec_pkg::PIX_W), .DEPTH(MAX_WIN * MAX_WIDTH)) u_band (
      .clock   (clock),
      .wr_en   (band_we),
      .wr_addr (band_waddr),
      .wr_data (pix_ff),
      .rd_addr (band_raddr),
      .rd_data (band_rd)
   );

   // ---------------- control ----------------
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = (KW'(er_ff) == wh_c - KW'(1)) && (KW'(ec_ff) == ww_c - KW'(1));

   always_comb begin
      cnt_new = (flags.first ? '0 : cnt_rd)
              + tec_pkg::CNT_W'(pix_ff == tec_pkg::PIX_EDGE);
   end

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      start_in     = start_ff;
      top_in       = top_ff;
      clear_in     = clear_ff;
      er_in        = er_ff;
      ec_in        = ec_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      advance      = 1'b0;
      cnt_we       = 1'b0;
      band_we      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               pix_in   = req_pixel_in;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (flags.in_tile) begin
               cnt_we   = 1'b1;
               band_we  = 1'b1;
               advance  = 1'b1;
               state_in = S_IDLE;
               if (flags.done) begin
                  clear_in = cnt_new < thr_ff;
                  start_in = start;
                  top_in   = row - RW'(rib);
                  er_in    = '0;
                  ec_in    = '0;
                  state_in = S_EMIT;
               end
            end else if (out_free) begin
               // pass through outside full tiles
               advance      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_pix_in   = pix_ff;
               rsp_row_in   = tec_pkg::OUT_W'(row);
               rsp_col_in   = tec_pkg::OUT_W'(col);
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            // read address is live; advance once the output slot frees
            if (out_free) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_pix_in   = clear_ff ? tec_pkg::PIX_WHITE : band_rd;
            rsp_row_in   = tec_pkg::OUT_W'(top_ff + RW'(er_ff));
            rsp_col_in   = tec_pkg::OUT_W'(start_ff + PW'(ec_ff));
            rsp_last_in  = emit_last;
            if (emit_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
               if (KW'(ec_ff) == ww_c - KW'(1)) begin
                  ec_in = '0;
                  er_in = er_ff + IW'(1);
               end else begin
                  ec_in = ec_ff + IW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      start_ff    <= start_in;
      top_ff      <= top_in;
      clear_ff    <= clear_in;
      er_ff       <= er_in;
      ec_ff       <= ec_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pix_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // ---------------- checks ----------------
`include "tile_edge_cleaner_assert.svh"

   `TEC_ASSERT(a_load_slot_free, (state_ff == S_LOAD) |-> !rsp_valid_ff, "load into busy slot")
   `TEC_ASSERT(a_upd_after_accept, (state_ff == S_UPD) |-> ($past(req_acc) || $past(state_ff == S_UPD)), "update without beat")
   `TEC_ASSERT(a_csr_restart, csr_restart |=> (col == '0) && (row == '0), "write did not restart")

endmodule

`default_nettype wire

// ----- rtl/core/tec_ram.sv -----
// ----------------------------------------------------------------------------
// tec_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/tec_tracker.sv -----
// ----------------------------------------------------------------------------
// tec_tracker
// Raster position of the next pixel and its place inside band and tile.
// ----------------------------------------------------------------------------
`default_nettype none

module tec_tracker #(
   parameter int PW = 12,
   parameter int RW = 12,
   parameter int KW = 4,
   parameter int IW = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    restart,
   input  wire logic                    advance,
   input  wire logic [PW-1:0]           w,
   input  wire logic [RW-1:0]           h,
   input  wire logic [KW-1:0]           ww,
   input  wire logic [KW-1:0]           wh,
   output logic      [PW-1:0]           col,
   output logic      [RW-1:0]           row,
   output logic      [IW-1:0]           cit,
   output logic      [IW-1:0]           rib,
   output tec_pkg::tile_flags_type      flags
);

   logic [PW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [IW-1:0] cit_ff, cit_in;
   logic [IW-1:0] rib_ff, rib_in;
   logic [PW:0]   tile_end;
   logic [RW:0]   band_end;
   logic [KW-1:0] cit_inc;
   logic [KW-1:0] rib_inc;

   assign col = col_ff;
   assign row = row_ff;
   assign cit = cit_ff;
   assign rib = rib_ff;

   // a pixel lies in a full tile when its tile and band end inside the image
   assign tile_end = (PW+1)'(col_ff - PW'(cit_ff)) + (PW+1)'(ww);
   assign band_end = (RW+1)'(row_ff - RW'(rib_ff)) + (RW+1)'(wh);
   assign flags.in_tile = (tile_end <= (PW+1)'(w)) && (band_end <= (RW+1)'(h));
   assign flags.first   = (cit_ff == '0) && (rib_ff == '0);
   assign flags.done    = (KW'(cit_ff) == ww - KW'(1)) && (KW'(rib_ff) == wh - KW'(1));

   assign cit_inc = KW'(cit_ff) + KW'(1);
   assign rib_inc = KW'(rib_ff) + KW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cit_in = cit_ff;
      rib_in = rib_ff;
      if (advance) begin
         col_in = col_ff + PW'(1);
         cit_in = (cit_inc >= ww) ? '0 : IW'(cit_inc);
         if (col_ff + PW'(1) >= w) begin
            col_in = '0;
            cit_in = '0;
            row_in = row_ff + RW'(1);
            rib_in = (rib_inc >= wh) ? '0 : IW'(rib_inc);
            if (row_ff + RW'(1) >= h) begin
               row_in = '0;
               rib_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         cit_ff <= '0;
         rib_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cit_ff <= cit_in;
         rib_ff <= rib_in;
      end
   end

endmodule

`default_nettype wire
